// ===== hdl/pprb_pkg.sv =====
// Package: shared constants, codes and types for the package priority request buffer.
`default_nettype none
package pprb_pkg;

    localparam int DEPTH       = 8;
    localparam int SOURCE_BITS = 4;
    localparam int TAG_BITS    = 16;

    localparam int IDX_W       = $clog2(DEPTH);
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int ACTIVE_W    = 4;
    localparam int OCC_FIELD_W = 4;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);
    localparam logic                REG_ACTIVE   = 1'b0;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             shift_en;
        logic [IDX_W-1:0] shift_idx;
    } t_cell_ctrl;

    typedef struct packed {
        logic en;
        logic first;
    } t_scan_ctrl;

    typedef struct packed {
        logic [IDX_W-1:0]       idx;
        logic [SOURCE_BITS-1:0] src;
        logic [TAG_BITS-1:0]    tag;
    } t_pick;

endpackage
`default_nettype wire

// ===== hdl/pprb_cells.sv =====
// Request cell store: prefix-packed source/tag registers with insert and close-gap shift.
`default_nettype none
module pprb_cells (
    input  wire logic                            i_clk,
    input  wire pprb_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic [pprb_pkg::SOURCE_BITS-1:0] i_wr_src,
    input  wire logic [pprb_pkg::TAG_BITS-1:0]    i_wr_tag,
    input  wire logic [pprb_pkg::IDX_W-1:0]       i_rd_idx,
    output logic      [pprb_pkg::SOURCE_BITS-1:0] o_rd_src,
    output logic      [pprb_pkg::TAG_BITS-1:0]    o_rd_tag
);
    import pprb_pkg::*;

    logic [SOURCE_BITS-1:0] r_src [DEPTH];
    logic [TAG_BITS-1:0]    r_tag [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_src[i_ctrl.wr_idx] <= i_wr_src;
            r_tag[i_ctrl.wr_idx] <= i_wr_tag;
        end else if (i_ctrl.shift_en) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (IDX_W'(i) >= i_ctrl.shift_idx) begin
                    r_src[i] <= r_src[i + 1];
                    r_tag[i] <= r_tag[i + 1];
                end
            end
        end
    end

    assign o_rd_src = r_src[i_rd_idx];
    assign o_rd_tag = r_tag[i_rd_idx];

endmodule
`default_nettype wire

// ===== hdl/pprb_scan.sv =====
// Shared compare unit: one cell per cycle, tracks first package match and oldest minimum source.
`default_nettype none
module pprb_scan (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pprb_pkg::t_scan_ctrl            i_ctrl,
    input  wire logic [pprb_pkg::IDX_W-1:0]       i_idx,
    input  wire logic [pprb_pkg::SOURCE_BITS-1:0] i_src,
    input  wire logic [pprb_pkg::TAG_BITS-1:0]    i_tag,
    input  wire logic                            i_pkg_set,
    input  wire logic [pprb_pkg::SOURCE_BITS-1:0] i_pkg_src,
    output pprb_pkg::t_pick                      o_pick
);
    import pprb_pkg::*;

    logic  r_found;
    t_pick r_pkg_hit;
    t_pick r_best;
    logic  hit;
    logic  better;

    assign hit    = i_ctrl.en && i_pkg_set && (i_src == i_pkg_src) && (i_ctrl.first || !r_found);
    assign better = i_ctrl.en && (i_ctrl.first || (i_src < r_best.src));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.en) begin
            if (i_ctrl.first) begin
                r_found <= hit;
            end else if (hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_pkg_hit <= '{idx: i_idx, src: i_src, tag: i_tag};
        end
        if (better) begin
            r_best <= '{idx: i_idx, src: i_src, tag: i_tag};
        end
    end

    assign o_pick = r_found ? r_pkg_hit : r_best;

endmodule
`default_nettype wire

// ===== hdl/package_priority_request_buffer.sv =====
// Top level: package priority request buffer with APB config, sequencer and result registers.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+----------------------------------------------
//  request   | start & !busy                      | i_action, i_source_id, i_request_tag
//  result    | o_done (one cycle)                 | o_status, o_served_source, o_served_tag,
//            |                                    | o_package_active, o_package_id, o_occupancy
//  config    | psel & penable & pwrite (pready=1) | paddr, pwdata, prdata
//
//  Offer and serve-on-empty: result appears in the cycle after accept, busy stays low.
//  Serve: the shared compare unit scans one occupied cell per cycle,
//  then the done state removes the pick and closes the gap.
//  Reset clears the buffer and the package; active_cells returns to 8.
//  Results cannot be stalled; a new transaction may start on the cycle of o_done.
`default_nettype none
module package_priority_request_buffer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pprb_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [pprb_pkg::DATA_W-1:0]          pwdata,
    output logic      [pprb_pkg::DATA_W-1:0]          prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_action,
    input  wire logic [pprb_pkg::SOURCE_BITS-1:0]     i_source_id,
    input  wire logic [pprb_pkg::TAG_BITS-1:0]        i_request_tag,
    output logic                                     o_done,
    output logic      [pprb_pkg::STATUS_W-1:0]        o_status,
    output logic      [pprb_pkg::SOURCE_BITS-1:0]     o_served_source,
    output logic      [pprb_pkg::TAG_BITS-1:0]        o_served_tag,
    output logic                                     o_package_active,
    output logic      [pprb_pkg::SOURCE_BITS-1:0]     o_package_id,
    output logic      [pprb_pkg::OCC_FIELD_W-1:0]     o_occupancy
);
    import pprb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [ACTIVE_W-1:0]    r_active;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_pkg_set, n_pkg_set;
    logic [SOURCE_BITS-1:0] r_pkg_src, n_pkg_src;

    logic                   n_done;
    logic [STATUS_W-1:0]    n_status;
    logic [SOURCE_BITS-1:0] n_served_src;
    logic [TAG_BITS-1:0]    n_served_tag;

    logic                   accept;
    logic                   cfg_wr;
    logic [OCC_W-1:0]       usable;
    logic                   last_cell;

    t_cell_ctrl             cell_ctrl;
    t_scan_ctrl             scan_ctrl;
    t_pick                  pick;
    logic [SOURCE_BITS-1:0] rd_src;
    logic [TAG_BITS-1:0]    rd_tag;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (cfg_wr && (paddr[ADDR_W-1] == REG_ACTIVE)) begin
            r_active <= pwdata[ACTIVE_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_ACTIVE) ? DATA_W'(r_active) : '0;

    always_comb begin
        if (r_active == '0) begin
            usable = OCC_W'(1);
        end else if (int'(r_active) > DEPTH) begin
            usable = OCC_W'(DEPTH);
        end else begin
            usable = OCC_W'(r_active);
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign last_cell = ((OCC_W'(r_idx) + OCC_W'(1)) == r_occ);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_pkg_set    = r_pkg_set;
        n_pkg_src    = r_pkg_src;
        n_done       = 1'b0;
        n_status     = o_status;
        n_served_src = '0;
        n_served_tag = '0;
        cell_ctrl    = '{wr_en: 1'b0, wr_idx: r_occ[IDX_W-1:0],
                         shift_en: 1'b0, shift_idx: pick.idx};
        scan_ctrl    = '{en: 1'b0, first: (r_idx == '0)};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_action == ACT_OFFER) begin
                        n_done = 1'b1;
                        if (r_occ < usable) begin
                            cell_ctrl.wr_en = 1'b1;
                            n_occ           = r_occ + OCC_W'(1);
                            n_status        = ST_ACCEPTED;
                        end else begin
                            n_status = ST_REJECTED;
                        end
                    end else if (r_occ == '0) begin
                        n_done    = 1'b1;
                        n_status  = ST_EMPTY;
                        n_pkg_set = 1'b0;
                        n_pkg_src = '0;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                scan_ctrl.en = 1'b1;
                if (last_cell) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                cell_ctrl.shift_en = 1'b1;
                n_occ        = r_occ - OCC_W'(1);
                n_pkg_set    = 1'b1;
                n_pkg_src    = pick.src;
                n_done       = 1'b1;
                n_status     = ST_SERVED;
                n_served_src = pick.src;
                n_served_tag = pick.tag;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_occ            <= '0;
            r_idx            <= '0;
            r_pkg_set        <= 1'b0;
            r_pkg_src        <= '0;
            o_done           <= 1'b0;
            o_status         <= ST_ACCEPTED;
            o_served_source  <= '0;
            o_served_tag     <= '0;
            o_package_active <= 1'b0;
            o_package_id     <= '0;
            o_occupancy      <= '0;
        end else begin
            r_state          <= n_state;
            r_occ            <= n_occ;
            r_idx            <= n_idx;
            r_pkg_set        <= n_pkg_set;
            r_pkg_src        <= n_pkg_src;
            o_done           <= n_done;
            o_status         <= n_status;
            o_served_source  <= n_served_src;
            o_served_tag     <= n_served_tag;
            o_package_active <= n_pkg_set;
            o_package_id     <= n_pkg_src;
            o_occupancy      <= OCC_FIELD_W'(n_occ);
        end
    end

    pprb_cells u_cells (
        .i_clk    (i_clk),
        .i_ctrl   (cell_ctrl),
        .i_wr_src (i_source_id),
        .i_wr_tag (i_request_tag),
        .i_rd_idx (r_idx),
        .o_rd_src (rd_src),
        .o_rd_tag (rd_tag)
    );

    pprb_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (scan_ctrl),
        .i_idx     (r_idx),
        .i_src     (rd_src),
        .i_tag     (rd_tag),
        .i_pkg_set (r_pkg_set),
        .i_pkg_src (r_pkg_src),
        .o_pick    (pick)
    );

    a_offer_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_OFFER)) |=> o_done)
        else $error("offer transaction did not complete in one cycle");

    a_served_sets_pkg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_SERVED)) |->
            (o_package_active && (o_package_id == o_served_source)))
        else $error("served source not made the package");

    a_empty_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> ((o_occupancy == '0) && !o_package_active))
        else $error("empty serve left state behind");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (OCC_W'(r_idx) < r_occ))
        else $error("scan index beyond occupancy");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy overflow");

endmodule
`default_nettype wire
